[src/cow_pkg.sv]
// shared widths, codes and types of the sector overlay mapper
`default_nettype none

package cow_pkg;

  localparam int unsigned CmdW       = 2;
  localparam int unsigned SectorW    = 14;
  localparam int unsigned SlotW      = 14;
  localparam int unsigned BlockW     = 9;
  localparam int unsigned SibW       = 5;
  localparam int unsigned SourceW    = 2;
  localparam int unsigned CntW       = 8;
  localparam int unsigned SecCountW  = 15;
  localparam int unsigned BlkCountW  = 10;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  // command codes, code 3 behaves as a query
  localparam logic [CmdW-1:0] CMD_READ  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

  localparam logic [SourceW-1:0] SRC_OVERLAY = 2'd0;
  localparam logic [SourceW-1:0] SRC_BLOCK   = 2'd1;
  localparam logic [SourceW-1:0] SRC_ZERO    = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic REG_SECTOR_COUNT = 1'b0;
  localparam logic REG_BLOCK_COUNT  = 1'b1;

  localparam logic [SecCountW-1:0] SectorCountReset = 15'd16384;
  localparam logic [BlkCountW-1:0] BlockCountReset  = 10'd0;

  typedef struct packed {
    logic               valid;
    logic [SlotW-1:0]   slot;
  } map_entry_t;

  typedef struct packed {
    logic               status;
    logic [SourceW-1:0] source;
    logic [SlotW-1:0]   slot;
    logic [BlockW-1:0]  block;
    logic [SibW-1:0]    sector_in_block;
    logic               needs_inflate;
    logic               new_slot;
    logic               overlaid;
    logic [CntW-1:0]    pages_used;
    logic [CntW-1:0]    used_in_last_page;
  } result_t;

endpackage

`default_nettype wire

[src/cow_sector_overlay_mapper_top.sv]
// sector overlay mapper: slot map memory, page allocator, block cache tag
// a taken word passes S_DIV and S_REM, then S_EVAL registers its result once the output is
//   free; one word at a time, in_ready_o low until then, for the map read-then-write and
//   two passes through the shared multiplier (reciprocal quotient, then remainder)
// reset: clears control state, then sweeps the slot map one entry a cycle
//   (MAX_SECTORS entries, capped at 16384) with in_ready_o low; config port works meanwhile
`default_nettype none

module cow_sector_overlay_mapper_top #(
  parameter int unsigned MAX_SECTORS       = 16384,
  parameter int unsigned SLOTS_PER_PAGE    = 128,
  parameter int unsigned SECTORS_PER_BLOCK = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // apb config port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [cow_pkg::PaddrW-1:0]     paddr,
  input  wire  [cow_pkg::PdataW-1:0]     pwdata,
  output logic [cow_pkg::PdataW-1:0]     prdata,
  output logic                           pready,
  // input channel
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [cow_pkg::CmdW-1:0]       command_i,
  input  wire  [cow_pkg::SectorW-1:0]    sector_i,
  // output channel
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           status_o,
  output logic [cow_pkg::SourceW-1:0]    source_o,
  output logic [cow_pkg::SlotW-1:0]      slot_o,
  output logic [cow_pkg::BlockW-1:0]     block_o,
  output logic [cow_pkg::SibW-1:0]       sector_in_block_o,
  output logic                           needs_inflate_o,
  output logic                           new_slot_o,
  output logic                           overlaid_o,
  output logic [cow_pkg::CntW-1:0]       pages_used_o,
  output logic [cow_pkg::CntW-1:0]       used_in_last_page_o
);

  import cow_pkg::*;

  localparam int unsigned MapDepth =
    (MAX_SECTORS < (1 << SectorW)) ? MAX_SECTORS : (1 << SectorW);
  localparam int unsigned AW     = $clog2(MapDepth);
  localparam int unsigned LogSpb = $clog2(SECTORS_PER_BLOCK);
  localparam int unsigned Shift  = SectorW + LogSpb;
  localparam int unsigned Recip  =
    ((1 << Shift) + SECTORS_PER_BLOCK - 1) / SECTORS_PER_BLOCK;
  localparam int unsigned MW     = $clog2(Recip + 1);
  localparam int unsigned PW     = SectorW + MW;
  localparam int unsigned RemW   = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
  localparam int unsigned FillW  = $clog2(SLOTS_PER_PAGE + 1);
  localparam int unsigned PageW  = $clog2(MapDepth + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_REM,
    S_EVAL
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        clr_q;
  logic [CmdW-1:0]      cmd_q;
  logic [SectorW-1:0]   sec_q;
  logic                 oor_q;
  logic [SectorW-1:0]   quo_q;
  logic [RemW-1:0]      rem_q;
  logic [PageW-1:0]     pc_q, pc_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic [SlotW-1:0]     base_q, base_d;
  logic [BlockW-1:0]    cb_q, cb_d;
  logic                 cv_q, cv_d;
  result_t              res_q, res_d;
  logic                 out_valid_q;

  logic [SecCountW-1:0] sector_count_q;
  logic [BlkCountW-1:0] block_count_q;

  map_entry_t           map_mem [MapDepth];
  map_entry_t           map_rd_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  map_entry_t           mem_wdata;
  logic                 alloc;
  logic [SlotW-1:0]     alloc_slot;

  logic                 in_fire;
  logic                 out_free;
  logic                 oor_d;

  // shared multiplier: quotient pass, then remainder pass
  logic [SectorW-1:0]   mul_a;
  logic [MW-1:0]        mul_b;
  logic [PW-1:0]        mul_p;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign oor_d = ({1'b0, sector_i} >= sector_count_q) ||
                 ({1'b0, sector_i} >= SecCountW'(MapDepth));

  assign mul_a = (state_q == S_DIV) ? sec_q : quo_q;
  assign mul_b = (state_q == S_DIV) ? MW'(Recip) : MW'(SECTORS_PER_BLOCK);
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // config port
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == REG_BLOCK_COUNT) begin
      prdata = PdataW'(block_count_q);
    end else begin
      prdata = PdataW'(sector_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_count_q <= SectorCountReset;
      block_count_q  <= BlockCountReset;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SECTOR_COUNT) begin
        sector_count_q <= pwdata[SecCountW-1:0];
      end else begin
        block_count_q <= pwdata[BlkCountW-1:0];
      end
    end
  end

  // evaluation of one word from the map entry and the divided sector
  always_comb begin
    res_d      = '0;
    pc_d       = pc_q;
    fill_d     = fill_q;
    base_d     = base_q;
    cb_d       = cb_q;
    cv_d       = cv_q;
    alloc      = 1'b0;
    alloc_slot = '0;
    if (oor_q) begin
      res_d.status = STATUS_RANGE;
    end else if (cmd_q == CMD_WRITE) begin
      res_d.overlaid = 1'b1;
      res_d.source   = SRC_OVERLAY;
      if (!map_rd_q.valid) begin
        alloc = 1'b1;
        if (pc_q == '0 || fill_q >= FillW'(SLOTS_PER_PAGE)) begin
          // open the next page
          pc_d   = pc_q + 1'b1;
          base_d = (pc_q == '0) ? '0 : base_q + SlotW'(SLOTS_PER_PAGE);
          alloc_slot = base_d;
          fill_d = FillW'(1);
        end else begin
          alloc_slot = base_q + SlotW'(fill_q);
          fill_d = fill_q + 1'b1;
        end
        res_d.new_slot = 1'b1;
        res_d.slot     = alloc_slot;
      end else begin
        res_d.slot = map_rd_q.slot;
      end
    end else if (cmd_q == CMD_READ) begin
      if (map_rd_q.valid) begin
        res_d.source   = SRC_OVERLAY;
        res_d.slot     = map_rd_q.slot;
        res_d.overlaid = 1'b1;
      end else if (quo_q >= SectorW'(block_count_q)) begin
        res_d.source = SRC_ZERO;
      end else begin
        res_d.source          = SRC_BLOCK;
        res_d.block           = BlockW'(quo_q);
        res_d.sector_in_block = SibW'(rem_q);
        if (!cv_q || cb_q != BlockW'(quo_q)) begin
          res_d.needs_inflate = 1'b1;
          cb_d = BlockW'(quo_q);
          cv_d = 1'b1;
        end
      end
    end else begin
      res_d.overlaid = map_rd_q.valid;
    end
    res_d.pages_used        = CntW'(pc_d);
    res_d.used_in_last_page = CntW'(fill_d);
  end

  // map write port: clearing sweep or allocation
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sec_q[AW-1:0];
    mem_wdata = '{valid: 1'b1, slot: alloc_slot};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_EVAL && out_free && alloc) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      map_rd_q <= map_mem[sector_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cmd_q       <= '0;
      sec_q       <= '0;
      oor_q       <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      pc_q        <= '0;
      fill_q      <= '0;
      base_q      <= '0;
      cb_q        <= '0;
      cv_q        <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_EVAL) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MapDepth - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            sec_q   <= sector_i;
            oor_q   <= oor_d;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          quo_q   <= SectorW'(mul_p >> Shift);
          state_q <= S_REM;
        end
        S_REM: begin
          rem_q   <= RemW'(sec_q - SectorW'(mul_p));
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (out_free) begin
            res_q       <= res_d;
            out_valid_q <= 1'b1;
            pc_q        <= pc_d;
            fill_q      <= fill_d;
            base_q      <= base_d;
            cb_q        <= cb_d;
            cv_q        <= cv_d;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = res_q.status;
  assign source_o            = res_q.source;
  assign slot_o              = res_q.slot;
  assign block_o             = res_q.block;
  assign sector_in_block_o   = res_q.sector_in_block;
  assign needs_inflate_o     = res_q.needs_inflate;
  assign new_slot_o          = res_q.new_slot;
  assign overlaid_o          = res_q.overlaid;
  assign pages_used_o        = res_q.pages_used;
  assign used_in_last_page_o = res_q.used_in_last_page;

endmodule

`default_nettype wire

[verif/tb_cow_sector_overlay_mapper_top.sv]
// testbench for the sector overlay mapper: random and directed accesses, self-checking
`default_nettype none

module tb_cow_sector_overlay_mapper_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cow_pkg::*;

  localparam int unsigned MaxSectors      = 16384;
  localparam int unsigned SlotsPerPage    = 128;
  localparam int unsigned SectorsPerBlock = 32;
  localparam int unsigned LongHoldCycles  = 300;
  localparam int unsigned LongHoldAfter   = 150;
  // code 3 has no name in the package; the block treats it as a query
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [SectorW-1:0] sector;
  } access_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PaddrW-1:0]    paddr = '0;
  logic [PdataW-1:0]    pwdata = '0;
  logic [PdataW-1:0]    prdata;
  logic                 pready;

  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  logic [CmdW-1:0]      command = CMD_READ;
  logic [SectorW-1:0]   sector = '0;

  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  logic                 status_o;
  logic [SourceW-1:0]   source_o;
  logic [SlotW-1:0]     slot_o;
  logic [BlockW-1:0]    block_o;
  logic [SibW-1:0]      sector_in_block_o;
  logic                 needs_inflate_o;
  logic                 new_slot_o;
  logic                 overlaid_o;
  logic [CntW-1:0]      pages_used_o;
  logic [CntW-1:0]      used_in_last_page_o;

  cow_sector_overlay_mapper_top #(
    .MAX_SECTORS      (MaxSectors),
    .SLOTS_PER_PAGE   (SlotsPerPage),
    .SECTORS_PER_BLOCK(SectorsPerBlock)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .command_i          (command),
    .sector_i           (sector),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .status_o           (status_o),
    .source_o           (source_o),
    .slot_o             (slot_o),
    .block_o            (block_o),
    .sector_in_block_o  (sector_in_block_o),
    .needs_inflate_o    (needs_inflate_o),
    .new_slot_o         (new_slot_o),
    .overlaid_o         (overlaid_o),
    .pages_used_o       (pages_used_o),
    .used_in_last_page_o(used_in_last_page_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the mapper state
  bit               map_valid [MaxSectors];
  bit [SlotW-1:0]   map_slot [MaxSectors];
  int unsigned      pages_open = 0;
  int unsigned      page_fill = 0;
  int unsigned      cached_blk = 0;
  bit               cached_ok = 1'b0;
  int unsigned      cfg_sector_count = 32'(SectorCountReset);
  int unsigned      cfg_block_count = 32'(BlockCountReset);
  int unsigned      written_q[$];

  access_t          access_q[$];
  result_t          sector_result_q[$];
  int unsigned      taken_cnt = 0;
  int unsigned      err_cnt = 0;
  bit               idle_on = 1'b1;

  int unsigned      word_cnt = 0;
  int unsigned      n_overlay = 0;
  int unsigned      n_block = 0;
  int unsigned      n_zero = 0;
  int unsigned      n_range = 0;
  int unsigned      n_inflate = 0;
  int unsigned      n_alloc = 0;

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("mismatch at word %0d: %s", word_cnt, msg);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // next mapper result for one access, updates the shadow state
  function automatic result_t map_sector_access(logic [CmdW-1:0] cmd, logic [SectorW-1:0] sec);
    result_t     r;
    int unsigned blk;
    r = '0;
    if (sec >= cfg_sector_count || sec >= MaxSectors) begin
      r.status = STATUS_RANGE;
    end else if (cmd == CMD_WRITE) begin
      if (!map_valid[sec]) begin
        if (pages_open == 0 || page_fill >= SlotsPerPage) begin
          pages_open++;
          page_fill = 0;
        end
        map_slot[sec] = SlotW'((pages_open - 1) * SlotsPerPage + page_fill);
        map_valid[sec] = 1'b1;
        page_fill++;
        r.new_slot = 1'b1;
        written_q.push_back(32'(sec));
      end
      r.source = SRC_OVERLAY;
      r.slot = map_slot[sec];
      r.overlaid = 1'b1;
    end else if (cmd == CMD_READ) begin
      if (map_valid[sec]) begin
        r.source = SRC_OVERLAY;
        r.slot = map_slot[sec];
        r.overlaid = 1'b1;
      end else begin
        blk = sec / SectorsPerBlock;
        if (blk >= cfg_block_count) begin
          r.source = SRC_ZERO;
        end else begin
          r.source = SRC_BLOCK;
          r.block = BlockW'(blk);
          r.sector_in_block = SibW'(sec % SectorsPerBlock);
          if (!cached_ok || cached_blk != blk) begin
            r.needs_inflate = 1'b1;
            cached_blk = blk;
            cached_ok = 1'b1;
          end
        end
      end
    end else begin
      r.overlaid = map_valid[sec];
    end
    r.pages_used = CntW'(pages_open);
    r.used_in_last_page = CntW'(page_fill);
    return r;
  endfunction

  // driver: one word per handshake, payload held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        sector_result_q.push_back(map_sector_access(command, sector));
        taken_cnt <= taken_cnt + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (access_q.size() != 0 && !(idle_on && $urandom_range(99) < 10)) begin
          in_valid <= 1'b1;
          command  <= access_q[0].command;
          sector   <= access_q[0].sector;
          void'(access_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off while the sender keeps going
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && taken_cnt >= LongHoldAfter) begin
      hold_done <= 1'b1;
      hold_cnt  <= LongHoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (sector_result_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = sector_result_q.pop_front();
        cmp_field("status", 16'(status_o), 16'(want.status));
        cmp_field("source", 16'(source_o), 16'(want.source));
        cmp_field("slot", 16'(slot_o), 16'(want.slot));
        cmp_field("block", 16'(block_o), 16'(want.block));
        cmp_field("sector_in_block", 16'(sector_in_block_o), 16'(want.sector_in_block));
        cmp_field("needs_inflate", 16'(needs_inflate_o), 16'(want.needs_inflate));
        cmp_field("new_slot", 16'(new_slot_o), 16'(want.new_slot));
        cmp_field("overlaid", 16'(overlaid_o), 16'(want.overlaid));
        cmp_field("pages_used", 16'(pages_used_o), 16'(want.pages_used));
        cmp_field("used_in_last_page", 16'(used_in_last_page_o),
                  16'(want.used_in_last_page));
        if (want.status == STATUS_RANGE) n_range++;
        else if (want.source == SRC_BLOCK) n_block++;
        else if (want.source == SRC_ZERO) n_zero++;
        else if (want.overlaid) n_overlay++;
        if (want.needs_inflate) n_inflate++;
        if (want.new_slot) n_alloc++;
      end
      word_cnt++;
    end
  end

  task automatic push_access(input logic [CmdW-1:0] cmd, input int unsigned sec);
    access_t a;
    a.command = cmd;
    a.sector = SectorW'(sec);
    access_q.push_back(a);
  endtask

  // mix of traffic: revisits of written sectors, a hot window, edges of range
  task automatic push_random(input int unsigned count);
    int unsigned     roll;
    int unsigned     sec;
    logic [CmdW-1:0] cmd;
    repeat (count) begin
      roll = $urandom_range(99);
      cmd = roll < 45 ? CMD_READ : roll < 80 ? CMD_WRITE : roll < 95 ? CMD_QUERY : CMD_SPARE;
      roll = $urandom_range(99);
      if (roll < 30 && written_q.size() != 0)
        sec = written_q[$urandom_range(written_q.size() - 1)];
      else if (roll < 55)
        sec = $urandom_range(95);
      else if (roll < 80)
        sec = $urandom_range((cfg_sector_count + 3 < MaxSectors) ?
                             cfg_sector_count + 3 : MaxSectors - 1);
      else
        sec = $urandom_range(MaxSectors - 1);
      push_access(cmd, sec);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (access_q.size() != 0 || in_valid || sector_result_q.size() != 0);
  endtask

  task automatic apb_cycle(input logic wr, input logic reg_idx, input int unsigned value,
                           output logic [PdataW-1:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned sec_cnt, input int unsigned blk_cnt);
    logic [PdataW-1:0] rd;
    apb_cycle(1'b1, REG_SECTOR_COUNT, sec_cnt, rd);
    apb_cycle(1'b1, REG_BLOCK_COUNT, blk_cnt, rd);
    cfg_sector_count = sec_cnt & 32'h7fff;
    cfg_block_count  = blk_cnt & 32'h3ff;
    apb_cycle(1'b0, REG_SECTOR_COUNT, 0, rd);
    if (rd !== PdataW'(cfg_sector_count))
      report_mismatch($sformatf("sector_count reads %h", rd));
    apb_cycle(1'b0, REG_BLOCK_COUNT, 0, rd);
    if (rd !== PdataW'(cfg_block_count))
      report_mismatch($sformatf("block_count reads %h", rd));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: with no blocks, every unwritten sector reads as zero fill
    push_access(CMD_READ, 5);
    push_access(CMD_QUERY, 16383);
    push_access(CMD_WRITE, 16383);
    wait_idle();

    // small disk, two blocks: range edge, zero fill, cache hits and misses
    set_geometry(100, 2);
    push_access(CMD_READ, 0);
    push_access(CMD_READ, 31);
    push_access(CMD_READ, 32);
    push_access(CMD_READ, 64);
    push_access(CMD_READ, 99);
    push_access(CMD_READ, 100);
    push_access(CMD_READ, 16383);
    push_access(CMD_WRITE, 16383);
    push_access(CMD_QUERY, 16383);
    push_access(CMD_WRITE, 0);
    push_access(CMD_WRITE, 0);
    push_access(CMD_READ, 0);
    push_access(CMD_QUERY, 0);
    push_access(CMD_SPARE, 0);
    push_access(CMD_QUERY, 1);
    push_access(CMD_SPARE, 16383);
    push_access(CMD_WRITE, 99);
    push_access(CMD_READ, 99);
    push_access(CMD_READ, 33);
    push_access(CMD_READ, 5);
    wait_idle();

    // full geometry, last block and last sector
    set_geometry(16384, 512);
    push_access(CMD_READ, 16382);
    push_access(CMD_WRITE, 16383);
    push_access(CMD_READ, 16383);
    push_access(CMD_READ, 8191);
    push_random(100);
    wait_idle();

    set_geometry(1, 0);
    push_random(40);
    wait_idle();

    // no idling for this stretch
    idle_on = 1'b0;
    set_geometry($urandom_range(16384, 1), $urandom_range(512, 0));
    push_random(100);
    wait_idle();
    idle_on = 1'b1;

    set_geometry(8192, 300);
    push_random(40);
    wait_idle();
    push_random(40);
    wait_idle();

    set_geometry(16384, 512);
    push_random(80);
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("covered %0d words: %0d overlay, %0d block (%0d inflates), %0d zero fill,",
             word_cnt, n_overlay, n_block, n_inflate, n_zero);
    $display("%0d out of range, %0d slot allocations over %0d pages", n_range, n_alloc,
             pages_open);
    if (sector_result_q.size() != 0) report_mismatch("results still outstanding at end");
    if (err_cnt == 0) begin
      $display("cow_sector_overlay_mapper_top test passed");
    end else begin
      $display("cow_sector_overlay_mapper_top test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("cow_sector_overlay_mapper_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
